### sv/ffmt_pkg.sv
`timescale 1ns / 1ps
// shared constants for the first-fit max tree allocator
// no dependencies; used by the channel interfaces and the top level
package ffmt_pkg;

  // fixed widths of the request, result and register fields
  localparam int SLOT_IDX_W = 11;
  localparam int AMOUNT_W   = 30;
  localparam int GRANT_W    = 11;
  localparam int CFG_W      = 11;

  // amounts are widened to this before masking to the capacity width
  localparam int AMT_EXT_W  = 32;

  // default sizing
  localparam int SLOTS_DEF  = 1024;
  localparam int CAP_W_DEF  = 30;

  // slot_count after reset
  localparam logic [CFG_W-1:0] CFG_COUNT_RST = 11'd1024;

  // request action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

endpackage

### sv/ffmt_req_if.sv
`timescale 1ns / 1ps
// request channel: valid/ready handshake with action, slot and amount
// depends on ffmt_pkg
interface ffmt_req_if import ffmt_pkg::*; ();

  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic [AMOUNT_W-1:0]   amount;

  modport source (output valid, action, slot_index, amount, input ready);
  modport sink   (input valid, action, slot_index, amount, output ready);

endinterface

### sv/ffmt_rsp_if.sv
`timescale 1ns / 1ps
// result channel: valid/ready handshake with the granted slot number
// depends on ffmt_pkg
interface ffmt_rsp_if import ffmt_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [GRANT_W-1:0] granted_slot;

  modport source (output valid, granted_slot, input ready);
  modport sink   (input valid, granted_slot, output ready);

endinterface

### sv/ffmt_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ffmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/first_fit_max_tree_allocator.sv
`timescale 1ns / 1ps
// channel   dir  payload                               handshake
// in_req    in   action, slot_index[10:0], amount[29:0] valid/ready
// out_rsp   out  granted_slot[10:0]                    valid/ready
// cfg       in   cfg_data[10:0] (slot_count)            cfg_we, no wait
//
// Tree memory entry n holds the maxima of both children of inner node n;
// the bottom entries hold the slot capacities themselves. L = clog2(SLOTS).
// A load reads the leaf-parent entry, then climbs level by level back to the
// root, reading each parent while writing the child entry.
// A request reads the root in the accepting cycle, then descends level by
// level to a leaf and, if a slot fits, writes the entries back up to the root;
// it then moves into the output register.
// After reset a clearing pass writes 2^L entries, one a cycle, with in_req
// held off. The result register frees the request side while a result
// waits; a request that finishes while that register is full holds there.
// Depends on ffmt_pkg, ffmt_req_if, ffmt_rsp_if and ffmt_ram.
module first_fit_max_tree_allocator import ffmt_pkg::*; #(
  parameter int SLOTS          = SLOTS_DEF,
  parameter int CAPACITY_WIDTH = CAP_W_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  ffmt_req_if.sink         in_req,
  ffmt_rsp_if.source       out_rsp
);

  localparam int LEVELS = $clog2(SLOTS);
  localparam int NODES  = 1 << LEVELS;
  localparam int NODE_W = LEVELS;
  localparam int CNT_W  = LEVELS + 1;
  localparam int CMP_W  = (CNT_W > SLOT_IDX_W) ? CNT_W : SLOT_IDX_W;
  localparam int CW     = CAPACITY_WIDTH;
  localparam int ENT_W  = 2 * CAPACITY_WIDTH;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_DESC   = 5'b00100,
    S_ASC    = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [NODE_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [NODE_W-1:0]   node_r, node_nxt;
  logic                side_r, side_nxt;
  logic [LEVELS-1:0]   base_r, base_nxt;
  logic [LEVELS-1:0]   half_r, half_nxt;
  logic [CW-1:0]       size_r, size_nxt;
  logic [CW-1:0]       carry_r, carry_nxt;
  logic                is_req_r, is_req_nxt;
  logic [GRANT_W-1:0]  grant_r, grant_nxt;
  logic [CFG_W-1:0]    cfg_count_r;
  logic                out_valid_r;
  logic [GRANT_W-1:0]  out_slot_r;

  logic                mem_we;
  logic [NODE_W-1:0]   mem_waddr;
  logic [ENT_W-1:0]    mem_wdata;
  logic                mem_re;
  logic [NODE_W-1:0]   mem_raddr;
  logic [ENT_W-1:0]    mem_rdata;

  // tree memory
  ffmt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NODES)
  ) u_tree_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // effective slot count
  logic [CMP_W-1:0] cfg_ext, slots_c, limit;
  assign cfg_ext = CMP_W'(cfg_count_r);
  assign slots_c = CMP_W'(SLOTS);
  assign limit   = (cfg_ext > slots_c) ? slots_c : cfg_ext;

  // request decode
  logic                 in_fire;
  logic [AMT_EXT_W-1:0] amt_ext;
  logic [CW-1:0]        amt_in;
  logic [CMP_W-1:0]     slot_ext;
  logic                 load_ok;
  logic [LEVELS-1:0]    load_off;
  logic [CNT_W-1:0]     load_leaf;
  logic [NODE_W-1:0]    load_node;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign amt_ext      = AMT_EXT_W'(in_req.amount);
  assign amt_in       = amt_ext[CW-1:0];
  assign slot_ext     = CMP_W'(in_req.slot_index);
  assign load_ok      = (slot_ext != '0) && (slot_ext <= limit);
  assign load_off     = LEVELS'(slot_ext - CMP_W'(1'b1));
  assign load_leaf    = {1'b1, load_off};
  assign load_node    = load_leaf[CNT_W-1:1];

  // read data split into left and right child maxima
  logic [CW-1:0] rd_left, rd_right;
  assign rd_left  = mem_rdata[ENT_W-1:CW];
  assign rd_right = mem_rdata[CW-1:0];

  // descent decision at the current node
  logic [CMP_W-1:0] mid_sum;
  logic             left_full, right_open, left_fit, right_fit;
  logic             at_leaf, go_left, go_right;
  assign mid_sum    = CMP_W'(base_r) + CMP_W'(half_r);
  assign left_full  = (mid_sum <= limit);
  assign right_open = (mid_sum < limit);
  assign left_fit   = (rd_left >= size_r);
  assign right_fit  = (rd_right >= size_r);
  assign at_leaf    = (half_r == LEVELS'(1'b1));
  assign go_left    = !left_full || left_fit;
  assign go_right   = !go_left && right_open;

  // leaf pick: subtract the size from the chosen slot
  logic          leaf_side, leaf_ok;
  logic [CW-1:0] leaf_val, leaf_max;
  logic [ENT_W-1:0] leaf_entry;
  assign leaf_side  = !left_fit;
  assign leaf_ok    = left_fit || (right_open && right_fit);
  assign leaf_val   = (leaf_side ? rd_right : rd_left) - size_r;
  assign leaf_entry = leaf_side ? {rd_left, leaf_val} : {leaf_val, rd_right};
  assign leaf_max   = leaf_side ? ((rd_left > leaf_val) ? rd_left : leaf_val)
                                : ((leaf_val > rd_right) ? leaf_val : rd_right);

  // ascent: replace one child maximum with the carried value
  logic [ENT_W-1:0] asc_entry;
  logic [CW-1:0]    asc_max;
  assign asc_entry = side_r ? {rd_left, carry_r} : {carry_r, rd_right};
  assign asc_max   = side_r ? ((rd_left > carry_r) ? rd_left : carry_r)
                            : ((carry_r > rd_right) ? carry_r : rd_right);

  logic             at_root;
  logic [NODE_W-1:0] parent;
  logic             out_load;
  assign at_root  = (node_r == NODE_W'(1'b1));
  assign parent   = node_r >> 1;
  assign out_load = (state_r == S_RESULT) && (!out_valid_r || out_rsp.ready);

  // sequencer and memory port control
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    node_nxt     = node_r;
    side_nxt     = side_r;
    base_nxt     = base_r;
    half_nxt     = half_r;
    size_nxt     = size_r;
    carry_nxt    = carry_r;
    is_req_nxt   = is_req_r;
    grant_nxt    = grant_r;
    mem_we       = 1'b0;
    mem_waddr    = node_r;
    mem_wdata    = asc_entry;
    mem_re       = 1'b0;
    mem_raddr    = parent;
    case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + NODE_W'(1'b1);
        if (clr_addr_r == NODE_W'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire && (in_req.action == ACT_ALLOC)) begin
          is_req_nxt = 1'b1;
          if (limit == '0) begin
            grant_nxt = '0;
            state_nxt = S_RESULT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = NODE_W'(1'b1);
            node_nxt  = NODE_W'(1'b1);
            base_nxt  = '0;
            half_nxt  = LEVELS'(NODES / 2);
            size_nxt  = amt_in;
            state_nxt = S_DESC;
          end
        end else if (in_fire && (in_req.action == ACT_LOAD) && load_ok) begin
          is_req_nxt = 1'b0;
          mem_re     = 1'b1;
          mem_raddr  = load_node;
          node_nxt   = load_node;
          side_nxt   = load_off[0];
          carry_nxt  = amt_in;
          state_nxt  = S_ASC;
        end
      end
      S_DESC: begin
        if (at_leaf) begin
          if (leaf_ok) begin
            // take from the leftmost fitting slot and start the way back up
            mem_we    = 1'b1;
            mem_wdata = leaf_entry;
            carry_nxt = leaf_max;
            grant_nxt = GRANT_W'(CMP_W'(base_r) + CMP_W'(leaf_side) + CMP_W'(1'b1));
            if (at_root) begin
              state_nxt = S_RESULT;
            end else begin
              mem_re    = 1'b1;
              node_nxt  = parent;
              side_nxt  = node_r[0];
              state_nxt = S_ASC;
            end
          end else begin
            grant_nxt = '0;
            state_nxt = S_RESULT;
          end
        end else if (go_left) begin
          mem_re    = 1'b1;
          mem_raddr = NODE_W'({node_r, 1'b0});
          node_nxt  = NODE_W'({node_r, 1'b0});
          half_nxt  = half_r >> 1;
        end else if (go_right) begin
          mem_re    = 1'b1;
          mem_raddr = NODE_W'({node_r, 1'b1});
          node_nxt  = NODE_W'({node_r, 1'b1});
          base_nxt  = base_r + half_r;
          half_nxt  = half_r >> 1;
        end else begin
          grant_nxt = '0;
          state_nxt = S_RESULT;
        end
      end
      S_ASC: begin
        // write the refreshed entry, fetch its parent unless at the root
        mem_we    = 1'b1;
        mem_wdata = asc_entry;
        carry_nxt = asc_max;
        if (at_root) begin
          state_nxt = is_req_r ? S_RESULT : S_IDLE;
        end else begin
          mem_re   = 1'b1;
          node_nxt = parent;
          side_nxt = node_r[0];
        end
      end
      S_RESULT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      cfg_count_r <= CFG_COUNT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (cfg_we) begin
        cfg_count_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    node_r   <= node_nxt;
    side_r   <= side_nxt;
    base_r   <= base_nxt;
    half_r   <= half_nxt;
    size_r   <= size_nxt;
    carry_r  <= carry_nxt;
    is_req_r <= is_req_nxt;
    grant_r  <= grant_nxt;
    if (out_load) begin
      out_slot_r <= grant_r;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.granted_slot = out_slot_r;

  // no read and write of the same entry in one cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("tree ram read and write collide");

  // the descent span stays a single power of two
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DESC) |-> $onehot(half_r))
    else $error("descent span corrupt");

  // the walk never sits on the unused entry zero
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DESC) || (state_r == S_ASC)) |-> (node_r != '0))
    else $error("tree walk at entry zero");

  // a granted slot lies within the slots in use
  assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (CMP_W'(grant_r) <= limit))
    else $error("granted slot beyond slot count");

endmodule

### test/first_fit_grant_checker.sv
`timescale 1ns / 1ps
// grant checker for the first-fit max tree allocator: watches the request,
// result and slot_count ports, predicts every grant and compares in order
// depends on ffmt_pkg, ffmt_req_if and ffmt_rsp_if
module first_fit_grant_checker import ffmt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  ffmt_req_if              req_mon,
  ffmt_rsp_if              rsp_mon,
  output int               grants_pending,
  output int               mismatch_total
);

  localparam int SLOT_TOTAL = SLOTS_DEF;

  // free capacity per slot; capacity width equals the amount width here
  logic [AMOUNT_W-1:0] free_cap [1:SLOT_TOTAL];
  logic [CFG_W-1:0]    slot_count = CFG_COUNT_RST;
  logic [GRANT_W-1:0]  grant_fifo [$];
  int                  errors = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  // slot_count above the slot total acts as the slot total
  function automatic int slots_in_use();
    return (slot_count > SLOT_TOTAL) ? SLOT_TOTAL : int'(slot_count);
  endfunction

  // leftmost slot in use with room takes the size; 0 when none fits
  function automatic logic [GRANT_W-1:0] claim_first_fit(input logic [AMOUNT_W-1:0] size);
    int top_slot;
    top_slot = slots_in_use();
    for (int s = 1; s <= top_slot; s++) begin
      if (free_cap[s] >= size) begin
        free_cap[s] = free_cap[s] - size;
        return GRANT_W'(s);
      end
    end
    return '0;
  endfunction

  always @(posedge clk) begin
    logic [GRANT_W-1:0] want;
    if (!rst_n) begin
      foreach (free_cap[s]) free_cap[s] = '0;
      slot_count = CFG_COUNT_RST;
      grant_fifo.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        slot_count = cfg_data;
      end
      // a grant leaving now belongs to an earlier request
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (grant_fifo.size() == 0) begin
          report_mismatch($sformatf("grant %0d with no request waiting",
                                    rsp_mon.granted_slot));
        end else begin
          want = grant_fifo.pop_front();
          if (rsp_mon.granted_slot !== want) begin
            report_mismatch($sformatf("granted_slot %0d, predicted %0d",
                                      rsp_mon.granted_slot, want));
          end
        end
      end
      // loads outside the slots in use change nothing
      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.action == ACT_ALLOC) begin
          grant_fifo.push_back(claim_first_fit(req_mon.amount));
        end else if (req_mon.slot_index >= 1 && req_mon.slot_index <= slots_in_use()) begin
          free_cap[req_mon.slot_index] = req_mon.amount;
        end
      end
    end
    grants_pending <= grant_fifo.size();
    mismatch_total <= errors;
  end

endmodule

### test/first_fit_max_tree_allocator_test.sv
`timescale 1ns / 1ps
// top of the first-fit allocator testbench: clock, reset, request stimulus,
// result back-pressure, slot_count phases and the verdict
// depends on ffmt_pkg, both channel interfaces, the allocator and the grant checker
module first_fit_max_tree_allocator_test;
  import ffmt_pkg::*;

  localparam int RUN_LIMIT  = 200000;
  localparam int DRAIN_TAIL = 40;
  localparam int LONG_HOLD  = 300;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;

  ffmt_req_if in_req ();
  ffmt_rsp_if out_rsp ();

  int               grants_pending;
  int               mismatch_total;
  int               cycle_count = 0;
  int               burst_left = 0;
  bit               steady_sender = 1'b0;
  bit               long_hold_req;
  bit               long_hold_taken = 1'b0;
  logic [CFG_W-1:0] active_count = CFG_COUNT_RST;

  first_fit_max_tree_allocator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_req   (in_req),
    .out_rsp  (out_rsp)
  );

  first_fit_grant_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .req_mon        (in_req),
    .rsp_mon        (out_rsp),
    .grants_pending (grants_pending),
    .mismatch_total (mismatch_total)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: steady runs, random stalls, and one long hold-off on demand
  initial begin
    out_rsp.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req && !long_hold_taken) begin
        out_rsp.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_taken = 1'b1;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            out_rsp.ready <= 1'b1;
            repeat ($urandom_range(10, 40)) @(posedge clk);
          end
          1, 2: begin
            repeat ($urandom_range(10, 30)) begin
              out_rsp.ready <= ($urandom_range(0, 3) != 0);
              @(posedge clk);
            end
          end
          default: begin
            out_rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
          end
        endcase
      end
    end
  end

  // one request, sent in bursts with random gaps between them
  task automatic offer_request(input logic act, input logic [SLOT_IDX_W-1:0] slot,
                               input logic [AMOUNT_W-1:0] amt);
    int gap;
    if (burst_left == 0) begin
      gap = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_req.valid      <= 1'b1;
    in_req.action     <= act;
    in_req.slot_index <= slot;
    in_req.amount     <= amt;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
  endtask

  task automatic load_slot(input logic [SLOT_IDX_W-1:0] slot, input logic [AMOUNT_W-1:0] amt);
    offer_request(ACT_LOAD, slot, amt);
  endtask

  // slot_index is unused on a request, so it carries noise
  task automatic request_size(input logic [AMOUNT_W-1:0] amt);
    offer_request(ACT_ALLOC, SLOT_IDX_W'($urandom), amt);
  endtask

  // stop sending, let every grant arrive, then let a trailing load finish
  task automatic wait_for_grants();
    in_req.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (grants_pending != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_slot_count(input logic [CFG_W-1:0] value);
    wait_for_grants();
    cfg_data <= value;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    active_count = value;
  endtask

  // mostly loads and requests that contend for the slots in use, a few loads anywhere
  task automatic random_item();
    int                    eff;
    int                    roll;
    logic [SLOT_IDX_W-1:0] slot;
    logic [AMOUNT_W-1:0]   amt;
    eff  = (active_count > SLOTS_DEF) ? SLOTS_DEF : int'(active_count);
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      if (roll < 4 || eff == 0) begin
        slot = SLOT_IDX_W'($urandom);
      end else begin
        slot = SLOT_IDX_W'($urandom_range(1, eff));
      end
      amt = ($urandom_range(0, 3) == 0) ? AMOUNT_W'($urandom)
                                        : AMOUNT_W'($urandom_range(0, 2000));
      load_slot(slot, amt);
    end else begin
      case ($urandom_range(0, 9))
        0:       amt = '0;
        1:       amt = AMOUNT_W'($urandom);
        default: amt = AMOUNT_W'($urandom_range(1, 1500));
      endcase
      request_size(amt);
    end
  endtask

  initial begin
    int phase_count [7] = '{16, 1, 2047, 0, 1024, 100, 3};
    int phase_len [7]   = '{70, 40, 70, 20, 80, 70, 100};

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_data          <= '0;
    in_req.valid      <= 1'b0;
    in_req.action     <= ACT_LOAD;
    in_req.slot_index <= '0;
    in_req.amount     <= '0;
    long_hold_req     <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // cleared tree, all slots in use: zero size fits slot 1, anything else nothing
    request_size('0);
    request_size(30'd1);
    // loads at slot 0 and above the count are dropped
    load_slot(11'd0, '1);
    load_slot(11'd2047, '1);
    load_slot(11'd1025, 30'd100);
    // extremes of slot and amount, alternating bit patterns
    load_slot(11'd1, '1);
    load_slot(11'd1024, 30'd5);
    load_slot(11'd1023, 30'h2AAAAAAA);
    load_slot(11'd512, 30'h15555555);
    request_size('1);
    request_size(30'h15555555);
    request_size(30'h15555555);
    request_size(30'h15555556);
    request_size(30'd5);
    request_size('0);
    load_slot(11'd1024, '0);
    load_slot(11'd2, 30'd7);
    request_size(30'd7);
    request_size(30'd1);

    // no slots in use: every request returns 0, loads dropped
    write_slot_count(11'd0);
    load_slot(11'd1, 30'd3);
    request_size('0);
    request_size(30'd3);

    // one slot in use
    write_slot_count(11'd1);
    load_slot(11'd1, 30'd9);
    load_slot(11'd2, 30'd50);
    request_size(30'd9);
    request_size(30'd1);

    // random phases over several slot counts
    for (int p = 0; p < 7; p++) begin
      write_slot_count(CFG_W'(phase_count[p]));
      if (p == 0) begin
        // keep offering requests while the result side holds off
        steady_sender = 1'b1;
        long_hold_req <= 1'b1;
      end else begin
        steady_sender = 1'b0;
      end
      for (int i = 0; i < phase_len[p]; i++) begin
        random_item();
        if ($urandom_range(0, 39) == 0) begin
          wait_for_grants();
        end
      end
    end

    wait_for_grants();
    if (mismatch_total == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
sv/ffmt_pkg.sv
sv/ffmt_req_if.sv
sv/ffmt_rsp_if.sv
sv/ffmt_ram.sv
sv/first_fit_max_tree_allocator.sv
test/first_fit_grant_checker.sv
test/first_fit_max_tree_allocator_test.sv
